@@ rtl/core/token_bucket_rate_limiter_assert.svh @@
// Assertion macros of the token bucket rate limiter, used by the tbrl_bucket module.
`ifndef TOKEN_BUCKET_RATE_LIMITER_ASSERT_SVH
`define TOKEN_BUCKET_RATE_LIMITER_ASSERT_SVH

// A condition that must hold at every rising clock edge outside reset.
`define TBRL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define TBRL_ASSERT_SAME(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define TBRL_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

@@ rtl/core/tbrl_pkg.sv @@
// Shared types and constants of the token bucket rate limiter.
`timescale 1ns / 1ps

package tbrl_pkg;

    localparam int TIME_BITS_DEFAULT  = 48;
    localparam int LEVEL_BITS_DEFAULT = 48;

    localparam int FIELD_W     = 48;
    localparam int RATE_W      = 32;
    localparam int MUL_W       = 32;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 4;
    localparam int REG_IDX_W   = 1;

    localparam logic [REG_IDX_W-1:0] REG_IDX_RATE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IDX_CAP  = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_GRANT    = 2'd0,
        VERDICT_DENY_LOW = 2'd1,
        VERDICT_DENY_CAP = 2'd2
    } verdict_t;

    typedef struct packed {
        logic wr;
        logic fill;
    } cfg_evt_t;

    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic s3_load;
    } pipe_load_t;

endpackage

@@ rtl/core/tbrl_cfg.sv @@
// Configuration registers of the token bucket rate limiter behind an APB-style port.
`timescale 1ns / 1ps

module tbrl_cfg #(
    parameter int LEVEL_BITS = tbrl_pkg::LEVEL_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tbrl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tbrl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tbrl_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [tbrl_pkg::RATE_W-1:0]     rate,
    output logic [LEVEL_BITS-1:0]           cap,
    output logic [LEVEL_BITS-1:0]           cap_next,
    output tbrl_pkg::cfg_evt_t              evt
);

    logic [tbrl_pkg::RATE_W-1:0]    rate_reg;
    logic [tbrl_pkg::RATE_W-1:0]    rate_next;
    logic [LEVEL_BITS-1:0]          cap_reg;
    logic [tbrl_pkg::REG_IDX_W-1:0] idx;
    logic                           wr;

    assign idx    = paddr[tbrl_pkg::APB_ADDR_W-1 -: tbrl_pkg::REG_IDX_W];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign rate   = rate_reg;
    assign cap    = cap_reg;

    always_comb
    begin
        rate_next = rate_reg;
        cap_next  = cap_reg;
        evt.wr    = wr;
        evt.fill  = 1'b0;
        if (wr)
        begin
            case (idx)
                tbrl_pkg::REG_IDX_RATE:
                begin
                    rate_next = pwdata[tbrl_pkg::RATE_W-1:0];
                end
                tbrl_pkg::REG_IDX_CAP:
                begin
                    cap_next = LEVEL_BITS'(pwdata[tbrl_pkg::FIELD_W-1:0]);
                    evt.fill = (cap_reg == '0);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            tbrl_pkg::REG_IDX_RATE: prdata = tbrl_pkg::APB_DATA_W'(rate_reg);
            tbrl_pkg::REG_IDX_CAP:  prdata = tbrl_pkg::APB_DATA_W'(cap_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= '0;
            cap_reg  <= '0;
        end
        else
        begin
            rate_reg <= rate_next;
            cap_reg  <= cap_next;
        end
    end

endmodule

@@ rtl/core/tbrl_prod.sv @@
// Input register and two-stage split multiplier forming timestamp times refill rate.
`timescale 1ns / 1ps

module tbrl_prod #(
    parameter int TIME_BITS = tbrl_pkg::TIME_BITS_DEFAULT
) (
    input  logic                          clk,
    input  tbrl_pkg::pipe_load_t          load,
    input  logic [tbrl_pkg::FIELD_W-1:0]  timestamp_us,
    input  logic [tbrl_pkg::FIELD_W-1:0]  token_cost,
    input  logic [tbrl_pkg::RATE_W-1:0]   rate,
    output logic [TIME_BITS+tbrl_pkg::MUL_W-1:0] prod,
    output logic [tbrl_pkg::FIELD_W-1:0]  cost
);

    localparam int PROD_W = TIME_BITS + tbrl_pkg::MUL_W;
    localparam int WIDE_W = 3 * tbrl_pkg::MUL_W;

    logic [TIME_BITS-1:0]             s1_ts_reg;
    logic [tbrl_pkg::FIELD_W-1:0]     s1_cost_reg;
    logic [2*tbrl_pkg::MUL_W-1:0]     s2_lo_reg;
    logic [2*tbrl_pkg::MUL_W-1:0]     s2_hi_reg;
    logic [tbrl_pkg::FIELD_W-1:0]     s2_cost_reg;
    logic [PROD_W-1:0]                s3_prod_reg;
    logic [tbrl_pkg::FIELD_W-1:0]     s3_cost_reg;

    logic [2*tbrl_pkg::MUL_W-1:0]     ts_wide;
    logic [2*tbrl_pkg::MUL_W-1:0]     lo_next;
    logic [2*tbrl_pkg::MUL_W-1:0]     hi_next;
    logic [WIDE_W-1:0]                sum_next;

    // The timestamp is split into two 32-bit halves, each multiplied separately.
    assign ts_wide  = (2*tbrl_pkg::MUL_W)'(s1_ts_reg);
    assign lo_next  = {{tbrl_pkg::MUL_W{1'b0}}, ts_wide[tbrl_pkg::MUL_W-1:0]}
                    * {{tbrl_pkg::MUL_W{1'b0}}, rate};
    assign hi_next  = {{tbrl_pkg::MUL_W{1'b0}}, ts_wide[2*tbrl_pkg::MUL_W-1:tbrl_pkg::MUL_W]}
                    * {{tbrl_pkg::MUL_W{1'b0}}, rate};
    assign sum_next = {{tbrl_pkg::MUL_W{1'b0}}, s2_lo_reg}
                    + {s2_hi_reg, {tbrl_pkg::MUL_W{1'b0}}};

    assign prod = s3_prod_reg;
    assign cost = s3_cost_reg;

    always_ff @(posedge clk)
    begin
        if (load.s1_load)
        begin
            s1_ts_reg   <= TIME_BITS'(timestamp_us);
            s1_cost_reg <= token_cost;
        end
        if (load.s2_load)
        begin
            s2_lo_reg   <= lo_next;
            s2_hi_reg   <= hi_next;
            s2_cost_reg <= s1_cost_reg;
        end
        if (load.s3_load)
        begin
            s3_prod_reg <= PROD_W'(sum_next);
            s3_cost_reg <= s2_cost_reg;
        end
    end

endmodule

@@ rtl/core/tbrl_bucket.sv @@
// Token level state, refill and grant decision, and the result register.
`timescale 1ns / 1ps

`include "token_bucket_rate_limiter_assert.svh"

module tbrl_bucket #(
    parameter int TIME_BITS  = tbrl_pkg::TIME_BITS_DEFAULT,
    parameter int LEVEL_BITS = tbrl_pkg::LEVEL_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    input  logic [TIME_BITS+tbrl_pkg::MUL_W-1:0] prod,
    input  logic [tbrl_pkg::FIELD_W-1:0]         cost,
    input  logic [LEVEL_BITS-1:0]                cap,
    input  logic [LEVEL_BITS-1:0]                cap_next,
    input  tbrl_pkg::cfg_evt_t                   cfg_evt,
    input  logic                                 rsp_stall,
    output logic                                 rsp_valid,
    output logic [1:0]                           verdict,
    output logic [tbrl_pkg::FIELD_W-1:0]         level_after,
    output logic                                 item_free
);

    localparam int PROD_W = TIME_BITS + tbrl_pkg::MUL_W;
    localparam int CMP_W  = 64;

    logic [LEVEL_BITS-1:0]         level_reg;
    logic [PROD_W-1:0]             last_prod_reg;
    logic                          fill_reg;
    logic                          restart_reg;
    logic                          out_valid_reg;
    tbrl_pkg::verdict_t            verdict_reg;
    logic [tbrl_pkg::FIELD_W-1:0]  level_out_reg;

    logic                          out_free;
    logic                          take;
    logic [LEVEL_BITS-1:0]         lvl0;
    logic [PROD_W-1:0]             lp0;
    logic [PROD_W-1:0]             inc;
    logic [LEVEL_BITS-1:0]         room;
    logic                          sat;
    logic [LEVEL_BITS-1:0]         lvl_ref;
    logic                          short_of_tokens;
    logic [LEVEL_BITS-1:0]         level_next;
    logic [PROD_W-1:0]             last_prod_next;
    tbrl_pkg::verdict_t            verdict_next;
    logic [LEVEL_BITS-1:0]         level_clamped;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign take      = item_valid && out_free;
    assign item_free = !item_valid || out_free;

    // Pending effects are applied before the request itself is looked at.
    assign lvl0 = fill_reg ? cap : level_reg;
    assign lp0  = restart_reg ? prod : last_prod_reg;

    // Both products share the same rate, so their difference is the elapsed time times the rate.
    assign inc     = (prod > lp0) ? (prod - lp0) : '0;
    assign room    = (lvl0 >= cap) ? '0 : (cap - lvl0);
    assign sat     = (inc > PROD_W'(room)) || (lvl0 > cap);
    assign lvl_ref = sat ? cap : (lvl0 + LEVEL_BITS'(inc));
    assign short_of_tokens = CMP_W'(lvl_ref) < CMP_W'(cost);

    always_comb
    begin
        level_next     = lvl0;
        last_prod_next = lp0;
        verdict_next   = tbrl_pkg::VERDICT_GRANT;
        if (cost == '0)
        begin
            verdict_next = tbrl_pkg::VERDICT_GRANT;
        end
        else if (cap == '0)
        begin
            verdict_next = tbrl_pkg::VERDICT_DENY_CAP;
        end
        else
        begin
            last_prod_next = prod;
            if (short_of_tokens)
            begin
                verdict_next = tbrl_pkg::VERDICT_DENY_LOW;
                level_next   = lvl_ref;
            end
            else
            begin
                verdict_next = tbrl_pkg::VERDICT_GRANT;
                level_next   = lvl_ref - LEVEL_BITS'(cost);
            end
        end
    end

    assign level_clamped = (level_reg > cap_next) ? cap_next : level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            last_prod_reg <= '0;
            fill_reg      <= 1'b1;
            restart_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_evt.wr)
            begin
                level_reg   <= level_clamped;
                restart_reg <= 1'b1;
                if (cfg_evt.fill)
                begin
                    fill_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                level_reg     <= level_next;
                last_prod_reg <= last_prod_next;
                fill_reg      <= 1'b0;
                restart_reg   <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            verdict_reg   <= verdict_next;
            level_out_reg <= tbrl_pkg::FIELD_W'(level_next);
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign verdict     = verdict_reg;
    assign level_after = level_out_reg;

    `TBRL_ASSERT_ALWAYS(a_level_within_cap, level_reg <= cap, "token level above capacity")
    `TBRL_ASSERT_SAME(a_zero_cap_empty, rsp_valid && (verdict_reg == tbrl_pkg::VERDICT_DENY_CAP), level_out_reg == '0, "zero-capacity denial reports a nonzero level")
    `TBRL_ASSERT_NEXT(a_pending_cleared, take && !cfg_evt.wr, !restart_reg && !fill_reg, "pending flags survived a request")

endmodule

@@ rtl/core/token_bucket_rate_limiter.sv @@
// Top level of the token bucket rate limiter.
// An accepted item passes the input, product and sum registers, then the result register.
// Throughput: one item per cycle unless rsp_stall is high; the refill multiply is split
// over two pipeline stages. The level update closes its loop in the decision stage.
// Reset: the bucket fills to capacity and restarts its refill clock on the first item.
`timescale 1ns / 1ps

module token_bucket_rate_limiter #(
    parameter int TIME_BITS  = tbrl_pkg::TIME_BITS_DEFAULT,
    parameter int LEVEL_BITS = tbrl_pkg::LEVEL_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tbrl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tbrl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tbrl_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [tbrl_pkg::FIELD_W-1:0]    timestamp_us,
    input  logic [tbrl_pkg::FIELD_W-1:0]    token_cost,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [1:0]                      verdict,
    output logic [tbrl_pkg::FIELD_W-1:0]    level_after
);

    localparam int PROD_W = TIME_BITS + tbrl_pkg::MUL_W;

    logic [tbrl_pkg::RATE_W-1:0]  rate;
    logic [LEVEL_BITS-1:0]        cap;
    logic [LEVEL_BITS-1:0]        cap_next;
    tbrl_pkg::cfg_evt_t           cfg_evt;
    tbrl_pkg::pipe_load_t         load;
    logic [PROD_W-1:0]            prod;
    logic [tbrl_pkg::FIELD_W-1:0] cost;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s1_free;
    logic s2_free;
    logic s3_free;

    assign s2_free   = !s2_valid_reg || s3_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign req_stall = !s1_free;

    assign load.s1_load = req_valid && s1_free;
    assign load.s2_load = s1_valid_reg && s2_free;
    assign load.s3_load = s2_valid_reg && s3_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    tbrl_cfg #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .rate     (rate),
        .cap      (cap),
        .cap_next (cap_next),
        .evt      (cfg_evt)
    );

    tbrl_prod #(
        .TIME_BITS (TIME_BITS)
    ) u_prod (
        .clk          (clk),
        .load         (load),
        .timestamp_us (timestamp_us),
        .token_cost   (token_cost),
        .rate         (rate),
        .prod         (prod),
        .cost         (cost)
    );

    tbrl_bucket #(
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_bucket (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s3_valid_reg),
        .prod        (prod),
        .cost        (cost),
        .cap         (cap),
        .cap_next    (cap_next),
        .cfg_evt     (cfg_evt),
        .rsp_stall   (rsp_stall),
        .rsp_valid   (rsp_valid),
        .verdict     (verdict),
        .level_after (level_after),
        .item_free   (s3_free)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the token bucket rate limiter with a built-in predictor.
`timescale 1ns / 1ps

module tb_top;
    import tbrl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_ITEMS  = 72;
    localparam logic [FIELD_W-1:0] ONE_TOKEN = 48'h1_0000;
    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    typedef struct packed {
        logic [FIELD_W-1:0] ts;
        logic [FIELD_W-1:0] cost;
    } request_t;

    typedef struct packed {
        verdict_t           verdict;
        logic [FIELD_W-1:0] level;
    } outcome_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid    = 1'b0;
    logic                  req_stall;
    logic [FIELD_W-1:0]    timestamp_us = '0;
    logic [FIELD_W-1:0]    token_cost   = '0;
    logic                  rsp_valid;
    logic                  rsp_stall    = 1'b0;
    logic [1:0]            verdict;
    logic [FIELD_W-1:0]    level_after;

    request_t pending_requests[$];
    outcome_t expected_outcomes[$];

    int send_idle_pct  = 26;
    int recv_stall_pct = 59;
    int mismatches     = 0;
    int stuck_cycles   = 0;

    logic [RATE_W-1:0]  rate_reg;
    logic [FIELD_W-1:0] cap_reg;
    logic [FIELD_W-1:0] bucket_level;
    logic [FIELD_W-1:0] last_refill_us;
    logic               fill_owed;
    logic               restart_owed;

    token_bucket_rate_limiter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .timestamp_us (timestamp_us),
        .token_cost   (token_cost),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .verdict      (verdict),
        .level_after  (level_after)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [FIELD_W-1:0] random48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[FIELD_W-1:0];
    endfunction

    task automatic predict_request(input logic [FIELD_W-1:0] now, input logic [FIELD_W-1:0] cost);
        logic [79:0]        gain;
        logic [FIELD_W-1:0] room;
        outcome_t           outcome;
        if (fill_owed)
        begin
            bucket_level = cap_reg;
            fill_owed    = 1'b0;
        end
        if (restart_owed)
        begin
            last_refill_us = now;
            restart_owed   = 1'b0;
        end
        if (cost == '0)
            outcome.verdict = VERDICT_GRANT;
        else if (cap_reg == '0)
            outcome.verdict = VERDICT_DENY_CAP;
        else
        begin
            if (now > last_refill_us && rate_reg != '0)
            begin
                room = (bucket_level >= cap_reg) ? '0 : cap_reg - bucket_level;
                gain = {32'd0, now - last_refill_us} * {48'd0, rate_reg};
                if (gain > {32'd0, room})
                    bucket_level = cap_reg;
                else
                    bucket_level = bucket_level + gain[FIELD_W-1:0];
                if (bucket_level > cap_reg)
                    bucket_level = cap_reg;
            end
            last_refill_us = now;
            if (bucket_level < cost)
                outcome.verdict = VERDICT_DENY_LOW;
            else
            begin
                bucket_level    = bucket_level - cost;
                outcome.verdict = VERDICT_GRANT;
            end
        end
        outcome.level = bucket_level;
        expected_outcomes.push_back(outcome);
    endtask

    task automatic apply_reg_write(input logic [REG_IDX_W-1:0] idx,
                                   input logic [APB_DATA_W-1:0] value);
        if (idx == REG_IDX_RATE)
            rate_reg = value[RATE_W-1:0];
        else
        begin
            if (cap_reg == '0)
                fill_owed = 1'b1;
            cap_reg = value[FIELD_W-1:0];
        end
        if (bucket_level > cap_reg)
            bucket_level = cap_reg;
        restart_owed = 1'b1;
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        apply_reg_write(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_request(input logic [FIELD_W-1:0] ts, input logic [FIELD_W-1:0] cost);
        request_t req;
        req.ts   = ts;
        req.cost = cost;
        pending_requests.push_back(req);
    endtask

    // Holds off until every queued item is sent and every result has come back.
    task automatic wait_drained();
        while (!(pending_requests.size() == 0 && !req_valid && expected_outcomes.size() == 0))
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : request_driver
        request_t req;
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
                predict_request(timestamp_us, token_cost);
            if (!req_valid || !req_stall)
            begin
                if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req = pending_requests.pop_front();
                    req_valid    <= 1'b1;
                    timestamp_us <= req.ts;
                    token_cost   <= req.cost;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        outcome_t exp_out;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result, verdict %0d level %h",
                             $time, verdict, level_after);
                    mismatches++;
                end
                else
                begin
                    exp_out = expected_outcomes.pop_front();
                    if (verdict !== exp_out.verdict)
                    begin
                        $display("%0t: verdict expected %0d, actual %0d",
                                 $time, exp_out.verdict, verdict);
                        mismatches++;
                    end
                    if (level_after !== exp_out.level)
                    begin
                        $display("%0t: level_after expected %h, actual %h",
                                 $time, exp_out.level, level_after);
                        mismatches++;
                    end
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles <= 0;
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin : stimulus
        logic [FIELD_W-1:0] ts;
        logic [FIELD_W-1:0] cap_new;
        logic [FIELD_W-1:0] span;
        logic [FIELD_W-1:0] cost;
        logic [FIELD_W-1:0] rate_wide;
        logic [RATE_W-1:0]  rate_new;
        int                 r;

        rate_reg       = '0;
        cap_reg        = '0;
        bucket_level   = '0;
        last_refill_us = '0;
        fill_owed      = 1'b1;
        restart_owed   = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Out of reset there is no capacity, so costs are refused and free items pass.
        queue_request(48'd100, 48'd5);
        queue_request(48'd0, 48'd0);
        wait_drained();

        write_reg(REG_IDX_RATE, 64'h0000_0000_0001_0000);
        write_reg(REG_IDX_CAP, 64'(10 * ONE_TOKEN));
        queue_request(48'd1000, 3 * ONE_TOKEN);
        queue_request(48'd1000, 7 * ONE_TOKEN);
        queue_request(48'd1002, 3 * ONE_TOKEN);
        queue_request(48'd1001, 48'd1);
        queue_request(48'd1101, 48'd1);
        queue_request(48'd1102, FIELD_MAX);
        queue_request(FIELD_MAX, 48'd1);
        queue_request(48'd0, 48'd0);
        queue_request(48'd5, 48'd1);
        wait_drained();

        // Lower the capacity under the level, then stop the refill.
        write_reg(REG_IDX_CAP, 64'(4 * ONE_TOKEN));
        write_reg(REG_IDX_RATE, 64'd0);
        queue_request(48'd50, ONE_TOKEN);
        queue_request(48'd60, ONE_TOKEN);
        wait_drained();

        write_reg(REG_IDX_CAP, 64'd0);
        queue_request(48'd70, 48'd1);
        queue_request(48'd71, 48'd0);
        wait_drained();

        write_reg(REG_IDX_RATE, 64'h0000_0000_FFFF_FFFF);
        write_reg(REG_IDX_CAP, 64'(FIELD_MAX));
        queue_request(48'd80, FIELD_MAX);
        queue_request(48'd81, FIELD_MAX);
        queue_request(FIELD_MAX, 48'd1);

        ts = 48'd200;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_drained();
            if (seg < 2)
            begin
                send_idle_pct  = 26;
                recv_stall_pct = 59;
            end
            else if (seg < 4)
            begin
                send_idle_pct  = 59;
                recv_stall_pct = 26;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            if ($urandom_range(0, 9) == 0)
                cap_new = '0;
            else
                cap_new = random48() >> (48 - $urandom_range(8, 48));
            r = $urandom_range(0, 7);
            if (r == 0)
                rate_new = '0;
            else if (r == 1)
                rate_new = $urandom();
            else
            begin
                rate_wide = cap_new >> $urandom_range(2, 14);
                rate_new  = (rate_wide > 48'hFFFF_FFFF) ? '1 : rate_wide[RATE_W-1:0];
            end
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(REG_IDX_CAP, {$urandom_range(0, 65535), cap_new});
                write_reg(REG_IDX_RATE, {$urandom(), rate_new});
            end
            else
            begin
                write_reg(REG_IDX_RATE, {$urandom(), rate_new});
                write_reg(REG_IDX_CAP, {$urandom_range(0, 65535), cap_new});
            end

            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    ts = ts + $urandom_range(0, 16);
                else if (r < 88)
                    ts = ts - $urandom_range(1, 50);
                else if (r < 93)
                    ts = random48();
                r = $urandom_range(0, 99);
                if (r < 6)
                    cost = '0;
                else if (r < 14 || cap_new == '0)
                    cost = random48();
                else
                begin
                    span = (cap_new >> $urandom_range(0, 5)) + 48'd1;
                    cost = random48() % span;
                end
                queue_request(ts, cost);
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
